>>> design/klk_pkg.sv
// package: types, codes and constants of the keypad code lock
`timescale 1ns / 1ps

package klk_pkg;

  localparam int DIGITS_DEF = 6;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [23:0] CODE_RST      = 24'h123456;
  localparam logic [3:0]  MAX_ERR_RST   = 4'd5;
  localparam logic [15:0] LOCK_MS_RST   = 16'd30000;
  localparam logic [15:0] BEEP_OK_RST   = 16'd100;
  localparam logic [15:0] BEEP_ERR_RST  = 16'd500;

  localparam logic [3:0]  DIGIT_MAX     = 4'd9;
  localparam logic [3:0]  FAIL_SAT      = 4'd15;

  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_ADVANCE = 3'd1,
    FUNC_STEP    = 3'd2,
    FUNC_CONFIRM = 3'd3,
    FUNC_ENTER   = 3'd4,
    FUNC_CLEAR   = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    STAT_DONE        = 3'd0,
    STAT_LOCKED      = 3'd1,
    STAT_INVALID     = 3'd2,
    STAT_NEED_MORE   = 3'd3,
    STAT_MATCH       = 3'd4,
    STAT_MISMATCH    = 3'd5,
    STAT_LOCKED_NOW  = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE     = 3'd0,
    CFG_MAX_ERR  = 3'd1,
    CFG_LOCK_MS  = 3'd2,
    CFG_BEEP_OK  = 3'd3,
    CFG_BEEP_ERR = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] digit;
  } event_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        open_pulse;
    logic        buzzer;
    logic        locked;
    logic [2:0]  cursor_pos;
    logic [2:0]  entered_count;
    logic [2:0]  missing_count;
    logic [3:0]  error_count;
    logic [15:0] lock_left;
    logic [23:0] entry_digits;
  } result_t;

  typedef struct packed {
    logic [23:0] correct_code;
    logic [3:0]  max_errors;
    logic [15:0] lock_ms;
    logic [15:0] beep_ok_ms;
    logic [15:0] beep_err_ms;
  } cfg_t;

endpackage

>>> design/klk_stream_if.sv
// interfaces: valid/ready channels for events and results
`timescale 1ns / 1ps

interface klk_event_if;
  logic              valid;
  logic              ready;
  klk_pkg::event_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface klk_result_if;
  logic              valid;
  logic              ready;
  klk_pkg::result_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> design/klk_cfg_regs.sv
// configuration register file of the keypad code lock
`timescale 1ns / 1ps

module klk_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [klk_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [klk_pkg::CFG_W-1:0]        cfg_wdata_i,
  output klk_pkg::cfg_t                    cfg_o
);

  klk_pkg::cfg_t cfg_q;
  klk_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        klk_pkg::CFG_CODE:     cfg_d.correct_code = 24'(cfg_wdata_i);
        klk_pkg::CFG_MAX_ERR:  cfg_d.max_errors   = 4'(cfg_wdata_i);
        klk_pkg::CFG_LOCK_MS:  cfg_d.lock_ms      = 16'(cfg_wdata_i);
        klk_pkg::CFG_BEEP_OK:  cfg_d.beep_ok_ms   = 16'(cfg_wdata_i);
        klk_pkg::CFG_BEEP_ERR: cfg_d.beep_err_ms  = 16'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.correct_code <= klk_pkg::CODE_RST;
      cfg_q.max_errors   <= klk_pkg::MAX_ERR_RST;
      cfg_q.lock_ms      <= klk_pkg::LOCK_MS_RST;
      cfg_q.beep_ok_ms   <= klk_pkg::BEEP_OK_RST;
      cfg_q.beep_err_ms  <= klk_pkg::BEEP_ERR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/klk_core.sv
// lock state and single-pass event logic of the keypad code lock
`timescale 1ns / 1ps

module klk_core #(
  parameter int DIGITS = klk_pkg::DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  klk_pkg::event_t   evt_i,
  input  klk_pkg::cfg_t     cfg_i,
  output klk_pkg::result_t  res_o
);

  localparam int CurW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CntW = $clog2(DIGITS + 1);
  localparam int PackW = 4 * DIGITS;

  logic [3:0]      entry_q [DIGITS];
  logic [3:0]      entry_d [DIGITS];
  logic [CurW-1:0] cursor_q, cursor_d;
  logic [CntW-1:0] count_q, count_d;
  logic [3:0]      fail_q, fail_d;
  logic            locked_q, locked_d;
  logic [15:0]     lock_tmr_q, lock_tmr_d;
  logic [15:0]     beep_q, beep_d;

  logic [3:0]       code_nib [DIGITS];
  logic [DIGITS-1:0] nib_match;
  logic [CurW-1:0]  cur_next;
  logic [CntW-1:0]  cur_plus1;
  logic [CntW-1:0]  miss_full;
  logic [PackW-1:0] packed_entry;
  logic [2:0]       status;
  logic             open_pulse;
  logic [2:0]       missing;

  for (genvar i = 0; i < DIGITS; i++) begin : g_nib
    localparam int Sh = 4 * (DIGITS - 1 - i);
    if (Sh < klk_pkg::CFG_W) begin : g_in
      assign code_nib[i] = cfg_i.correct_code[Sh +: 4];
    end else begin : g_out
      assign code_nib[i] = 4'd0;
    end
    assign nib_match[i] = (entry_q[i] == code_nib[i]);
  end

  assign cur_next  = (cursor_q == CurW'(DIGITS - 1)) ? '0 : cursor_q + CurW'(1);
  assign cur_plus1 = CntW'(cursor_q) + CntW'(1);
  assign miss_full = CntW'(DIGITS) - count_q;

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      entry_d[k] = entry_q[k];
    end
    cursor_d   = cursor_q;
    count_d    = count_q;
    fail_d     = fail_q;
    locked_d   = locked_q;
    lock_tmr_d = lock_tmr_q;
    beep_d     = beep_q;
    status     = klk_pkg::STAT_DONE;
    open_pulse = 1'b0;
    missing    = 3'd0;

    if (step_i) begin
      if (evt_i.func == klk_pkg::FUNC_TICK) begin
        if (beep_q != 16'd0) begin
          beep_d = beep_q - 16'd1;
        end
        if (locked_q) begin
          if (lock_tmr_q <= 16'd1) begin
            locked_d   = 1'b0;
            lock_tmr_d = 16'd0;
            fail_d     = 4'd0;
            for (int k = 0; k < DIGITS; k++) begin
              entry_d[k] = 4'd0;
            end
            cursor_d = '0;
            count_d  = '0;
          end else begin
            lock_tmr_d = lock_tmr_q - 16'd1;
          end
        end
      end else if (locked_q) begin
        status = klk_pkg::STAT_LOCKED;
      end else begin
        case (evt_i.func)
          klk_pkg::FUNC_ADVANCE: begin
            cursor_d = cur_next;
          end
          klk_pkg::FUNC_STEP: begin
            entry_d[cursor_q] = (entry_q[cursor_q] < klk_pkg::DIGIT_MAX) ?
                                entry_q[cursor_q] + 4'd1 : 4'd0;
            if (cur_plus1 > count_q) begin
              count_d = cur_plus1;
            end
          end
          klk_pkg::FUNC_CONFIRM: begin
            if (count_q < CntW'(DIGITS)) begin
              status  = klk_pkg::STAT_NEED_MORE;
              missing = 3'(miss_full);
            end else begin
              for (int k = 0; k < DIGITS; k++) begin
                entry_d[k] = 4'd0;
              end
              cursor_d = '0;
              count_d  = '0;
              if (&nib_match) begin
                status     = klk_pkg::STAT_MATCH;
                open_pulse = 1'b1;
                fail_d     = 4'd0;
                beep_d     = cfg_i.beep_ok_ms;
              end else begin
                fail_d = (fail_q == klk_pkg::FAIL_SAT) ? fail_q : fail_q + 4'd1;
                beep_d = cfg_i.beep_err_ms;
                status = klk_pkg::STAT_MISMATCH;
                if (fail_d >= cfg_i.max_errors) begin
                  status     = klk_pkg::STAT_LOCKED_NOW;
                  locked_d   = 1'b1;
                  lock_tmr_d = cfg_i.lock_ms;
                end
              end
            end
          end
          klk_pkg::FUNC_ENTER: begin
            if (evt_i.digit > klk_pkg::DIGIT_MAX || count_q >= CntW'(DIGITS)) begin
              status = klk_pkg::STAT_INVALID;
            end else begin
              entry_d[cursor_q] = evt_i.digit;
              cursor_d          = cur_next;
              count_d           = count_q + CntW'(1);
            end
          end
          klk_pkg::FUNC_CLEAR: begin
            for (int k = 0; k < DIGITS; k++) begin
              entry_d[k] = 4'd0;
            end
            cursor_d = '0;
            count_d  = '0;
          end
          default: begin
            status = klk_pkg::STAT_INVALID;
          end
        endcase
      end
    end
  end

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      packed_entry[4 * (DIGITS - 1 - k) +: 4] = entry_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIGITS; k++) begin
        entry_q[k] <= 4'd0;
      end
      cursor_q   <= '0;
      count_q    <= '0;
      fail_q     <= 4'd0;
      locked_q   <= 1'b0;
      lock_tmr_q <= 16'd0;
      beep_q     <= 16'd0;
    end else begin
      for (int k = 0; k < DIGITS; k++) begin
        entry_q[k] <= entry_d[k];
      end
      cursor_q   <= cursor_d;
      count_q    <= count_d;
      fail_q     <= fail_d;
      locked_q   <= locked_d;
      lock_tmr_q <= lock_tmr_d;
      beep_q     <= beep_d;
    end
  end

  assign res_o.status        = status;
  assign res_o.open_pulse    = open_pulse;
  assign res_o.buzzer        = (beep_d != 16'd0);
  assign res_o.locked        = locked_d;
  assign res_o.cursor_pos    = 3'(cursor_d);
  assign res_o.entered_count = 3'(count_d);
  assign res_o.missing_count = missing;
  assign res_o.error_count   = fail_d;
  assign res_o.lock_left     = locked_d ? lock_tmr_d : 16'd0;
  assign res_o.entry_digits  = 24'(packed_entry);

endmodule

>>> design/keypad_code_lock_lockout.sv
// keypad code lock with error lockout and buzzer timing, top level
// an event transfer is held in the event register, and its result in the result register
// throughput: one event per cycle while the result sink takes results, set by the single-pass state update in klk_core
// a full result register with a stalled sink holds the event register, then ready drops
// reset: entry, cursor, counts, lockout and buzzer cleared, config back to defaults
`timescale 1ns / 1ps

module keypad_code_lock_lockout #(
  parameter int DIGITS = klk_pkg::DIGITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [klk_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [klk_pkg::CFG_W-1:0]      cfg_wdata_i,
  klk_event_if.sink                      evt_i,
  klk_result_if.source                   res_o
);

  klk_pkg::cfg_t    cfg;
  klk_pkg::result_t step_res;

  logic             in_valid_q;
  klk_pkg::event_t  in_pay_q;
  logic             out_valid_q;
  klk_pkg::result_t out_pay_q;
  logic             advance;
  logic             in_xfer;

  klk_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  klk_core #(
    .DIGITS (DIGITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .evt_i  (in_pay_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || advance;
  assign in_xfer     = evt_i.valid && evt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (evt_i.ready) begin
        in_valid_q <= evt_i.valid;
      end
      if (!out_valid_q || res_o.ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_pay_q <= evt_i.payload;
    end
    if (advance) begin
      out_pay_q <= step_res;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_pay_q;

endmodule

>>> bench/klk_checker.sv
// checker: predicts keypad lock results from observed transfers and compares them
`timescale 1ns / 1ps

module klk_checker
  import klk_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 evt_valid_i,
  input  logic                 evt_ready_i,
  input  event_t               evt_payload_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  result_t              res_payload_i,
  output int unsigned          pending_o,
  output int unsigned          errors_o
);

  localparam int NDIG = DIGITS_DEF;

  cfg_t        settings;
  logic [3:0]  entry_nib [NDIG];
  logic [2:0]  cursor;
  logic [2:0]  filled;
  logic [3:0]  fails;
  logic        lock_on;
  logic [15:0] lock_cnt;
  logic [15:0] beep_cnt;
  result_t     expected_q [$];

  function automatic void wipe_entry();
    int i;
    for (i = 0; i < NDIG; i++) entry_nib[i] = '0;
    cursor = '0;
    filled = '0;
  endfunction

  function automatic result_t apply_event(event_t ev);
    result_t    r;
    logic [2:0] pos;
    logic       same;
    int         i;
    r = '0;
    r.status = STAT_DONE;
    pos = 3'(cursor % NDIG);
    if (ev.func == FUNC_TICK) begin
      if (beep_cnt != 0) beep_cnt--;
      if (lock_on) begin
        if (lock_cnt <= 1) begin
          lock_on = 1'b0;
          lock_cnt = '0;
          fails = '0;
          wipe_entry();
        end else begin
          lock_cnt--;
        end
      end
    end else if (lock_on) begin
      r.status = STAT_LOCKED;
    end else begin
      case (ev.func)
        FUNC_ADVANCE: cursor = 3'((pos + 1) % NDIG);
        FUNC_STEP: begin
          entry_nib[pos] = (entry_nib[pos] < DIGIT_MAX) ? entry_nib[pos] + 4'd1 : '0;
          if (pos + 1 > filled) filled = pos + 3'd1;
        end
        FUNC_CONFIRM: begin
          if (filled < NDIG) begin
            r.status = STAT_NEED_MORE;
            r.missing_count = 3'(NDIG - filled);
          end else begin
            same = 1'b1;
            for (i = 0; i < NDIG; i++) begin
              if (entry_nib[i] != settings.correct_code[4*(NDIG-1-i) +: 4]) same = 1'b0;
            end
            wipe_entry();
            if (same) begin
              r.status = STAT_MATCH;
              r.open_pulse = 1'b1;
              fails = '0;
              beep_cnt = settings.beep_ok_ms;
            end else begin
              if (fails < FAIL_SAT) fails++;
              beep_cnt = settings.beep_err_ms;
              r.status = STAT_MISMATCH;
              if (fails >= settings.max_errors) begin
                r.status = STAT_LOCKED_NOW;
                lock_on = 1'b1;
                lock_cnt = settings.lock_ms;
              end
            end
          end
        end
        FUNC_ENTER: begin
          if (ev.digit > DIGIT_MAX || filled >= NDIG) begin
            r.status = STAT_INVALID;
          end else begin
            entry_nib[pos] = ev.digit;
            cursor = 3'((pos + 1) % NDIG);
            filled++;
          end
        end
        FUNC_CLEAR: wipe_entry();
        default: r.status = STAT_INVALID;
      endcase
    end
    r.buzzer = (beep_cnt != 0);
    r.locked = lock_on;
    r.cursor_pos = cursor;
    r.entered_count = filled;
    r.error_count = fails;
    r.lock_left = lock_on ? lock_cnt : '0;
    for (i = 0; i < NDIG; i++) r.entry_digits = {r.entry_digits[19:0], entry_nib[i]};
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      settings = '{correct_code: CODE_RST, max_errors: MAX_ERR_RST, lock_ms: LOCK_MS_RST,
                   beep_ok_ms: BEEP_OK_RST, beep_err_ms: BEEP_ERR_RST};
      wipe_entry();
      fails = '0;
      lock_on = 1'b0;
      lock_cnt = '0;
      beep_cnt = '0;
      expected_q.delete();
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CODE:     settings.correct_code = cfg_wdata_i;
          CFG_MAX_ERR:  settings.max_errors = cfg_wdata_i[3:0];
          CFG_LOCK_MS:  settings.lock_ms = cfg_wdata_i[15:0];
          CFG_BEEP_OK:  settings.beep_ok_ms = cfg_wdata_i[15:0];
          CFG_BEEP_ERR: settings.beep_err_ms = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (evt_valid_i && evt_ready_i) expected_q.push_back(apply_event(evt_payload_i));
      if (res_valid_i && res_ready_i) begin
        if (expected_q.size() == 0) begin
          errors_o++;
          $display("%0t: result mismatch, expected none, got %0h", $time, res_payload_i);
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, res_payload_i.status);
          check_field("open_pulse", want.open_pulse, res_payload_i.open_pulse);
          check_field("buzzer", want.buzzer, res_payload_i.buzzer);
          check_field("locked", want.locked, res_payload_i.locked);
          check_field("cursor_pos", want.cursor_pos, res_payload_i.cursor_pos);
          check_field("entered_count", want.entered_count, res_payload_i.entered_count);
          check_field("missing_count", want.missing_count, res_payload_i.missing_count);
          check_field("error_count", want.error_count, res_payload_i.error_count);
          check_field("lock_left", want.lock_left, res_payload_i.lock_left);
          check_field("entry_digits", want.entry_digits, res_payload_i.entry_digits);
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// testbench top: keypad lock stimulus, settings phases and verdict
`timescale 1ns / 1ps

module tb_top;
  import klk_pkg::*;

  localparam int          NDIG         = DIGITS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 160;
  localparam logic [2:0]  FUNC_SPARE_A = 3'd6;
  localparam logic [2:0]  FUNC_SPARE_B = 3'd7;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int unsigned          pending;
  int unsigned          errors;
  int unsigned          cycles = 0;
  int unsigned          send_idle = 0;
  int unsigned          recv_stall = 0;
  int unsigned          hold_req = 0;
  int unsigned          hold_done = 0;
  int unsigned          sent_in_phase = 0;
  cfg_t                 lock_cfg;

  klk_event_if  evt_if ();
  klk_result_if res_if ();

  keypad_code_lock_lockout u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .evt_i       (evt_if),
    .res_o       (res_if)
  );

  klk_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .evt_valid_i   (evt_if.valid),
    .evt_ready_i   (evt_if.ready),
    .evt_payload_i (evt_if.payload),
    .res_valid_i   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .res_payload_i (res_if.payload),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_done != hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done++;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  function automatic logic [3:0] rnd_digit();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [3:0] code_digit(int i);
    return lock_cfg.correct_code[4*(NDIG-1-i) +: 4];
  endfunction

  function automatic cfg_t rand_settings();
    cfg_t s;
    int   i;
    for (i = 0; i < NDIG; i++) s.correct_code[4*i +: 4] = 4'($urandom_range(0, 9));
    if ($urandom_range(0, 7) == 0) s.correct_code = 24'($urandom());
    s.max_errors  = 4'($urandom_range(1, 6));
    s.lock_ms     = 16'($urandom_range(1, 40));
    s.beep_ok_ms  = 16'($urandom_range(0, 30));
    s.beep_err_ms = 16'($urandom_range(0, 30));
    return s;
  endfunction

  task automatic send(input logic [2:0] f, input logic [3:0] d);
    while ($urandom_range(0, 99) < send_idle) begin
      evt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_if.valid <= 1'b1;
    evt_if.payload <= '{func: f, digit: d};
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    sent_in_phase++;
  endtask

  // wait until every transfer has its result, then let the pipeline empty
  task automatic settle();
    evt_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_lock(input cfg_t s);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_CODE;
    cfg_wdata <= s.correct_code;
    @(posedge clk_i);
    cfg_idx <= CFG_MAX_ERR;
    cfg_wdata <= CFG_W'(s.max_errors);
    @(posedge clk_i);
    cfg_idx <= CFG_LOCK_MS;
    cfg_wdata <= CFG_W'(s.lock_ms);
    @(posedge clk_i);
    cfg_idx <= CFG_BEEP_OK;
    cfg_wdata <= CFG_W'(s.beep_ok_ms);
    @(posedge clk_i);
    cfg_idx <= CFG_BEEP_ERR;
    cfg_wdata <= CFG_W'(s.beep_err_ms);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    lock_cfg = s;
  endtask

  task automatic directed_events();
    int i;
    send(FUNC_CONFIRM, rnd_digit());
    send(FUNC_ENTER, 4'hF);
    for (i = 0; i < NDIG; i++) send(FUNC_ENTER, code_digit(i));
    send(FUNC_ENTER, DIGIT_MAX);
    send(FUNC_CONFIRM, '0);
    send(FUNC_TICK, 4'hF);
    send(FUNC_SPARE_A, rnd_digit());
    send(FUNC_SPARE_B, rnd_digit());
    send(FUNC_STEP, '0);
    for (i = 0; i < NDIG; i++) send(FUNC_ADVANCE, rnd_digit());
    send(FUNC_STEP, rnd_digit());
    send(FUNC_ENTER, '0);
    send(FUNC_ENTER, DIGIT_MAX);
    send(FUNC_CLEAR, rnd_digit());
  endtask

  task automatic random_attempt();
    int unsigned kind;
    int unsigned n;
    int          i;
    logic [3:0]  d;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) send(FUNC_CLEAR, rnd_digit());
    if (kind < 50) begin
      for (i = 0; i < NDIG; i++) begin
        d = code_digit(i);
        if ($urandom_range(0, 7) == 0) d = rnd_digit();
        send(FUNC_ENTER, d);
      end
      send(FUNC_CONFIRM, rnd_digit());
    end else if (kind < 70) begin
      n = $urandom_range(0, NDIG + 1);
      repeat (n) send(FUNC_ENTER, 4'($urandom_range(0, 9)));
      send(FUNC_CONFIRM, rnd_digit());
    end else if (kind < 85) begin
      for (i = 0; i < NDIG; i++) begin
        n = 32'(code_digit(i));
        if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 12);
        repeat (n) send(FUNC_STEP, rnd_digit());
        send(FUNC_ADVANCE, rnd_digit());
      end
      send(FUNC_CONFIRM, rnd_digit());
    end else begin
      repeat ($urandom_range(1, 10)) send(3'($urandom_range(0, 7)), rnd_digit());
    end
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * lock_cfg.lock_ms + 4)
                                    : $urandom_range(0, 3);
    repeat (n) send(FUNC_TICK, rnd_digit());
  endtask

  task automatic random_phase(input cfg_t s, input int unsigned idle_s,
                              input int unsigned idle_r, input bit hold);
    settle();
    program_lock(s);
    send_idle = idle_s;
    recv_stall = idle_r;
    if (hold) hold_req++;
    sent_in_phase = 0;
    while (sent_in_phase < PHASE_ITEMS) random_attempt();
  endtask

  task automatic long_lockout_phase();
    cfg_t s;
    int   i;
    s = rand_settings();
    s.max_errors  = 4'd1;
    s.lock_ms     = 16'hFFFF;
    s.beep_ok_ms  = 16'hFFFF;
    s.beep_err_ms = 16'hFFFF;
    settle();
    program_lock(s);
    send_idle = 0;
    recv_stall = 0;
    send(FUNC_CLEAR, rnd_digit());
    send(FUNC_ENTER, (code_digit(0) >= DIGIT_MAX) ? 4'd0 : code_digit(0) + 4'd1);
    for (i = 1; i < NDIG; i++) send(FUNC_ENTER, code_digit(i));
    send(FUNC_CONFIRM, rnd_digit());
    send(FUNC_ENTER, code_digit(0));
    send(FUNC_SPARE_B, rnd_digit());
    repeat (8) send(FUNC_TICK, rnd_digit());
    for (i = 0; i < NDIG; i++) send(FUNC_ENTER, code_digit(i));
    send(FUNC_CONFIRM, rnd_digit());
    repeat (3) send(FUNC_TICK, rnd_digit());
  endtask

  initial begin
    int   p;
    cfg_t s;
    evt_if.valid <= 1'b0;
    evt_if.payload <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_CODE;
    cfg_wdata <= '0;
    rst_ni <= 1'b0;
    lock_cfg = '{correct_code: CODE_RST, max_errors: MAX_ERR_RST, lock_ms: LOCK_MS_RST,
                 beep_ok_ms: BEEP_OK_RST, beep_err_ms: BEEP_ERR_RST};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_events();

    // extremes: nines code with no beep, zeros code, unmatchable code with instant lock
    random_phase('{24'h999999, 4'd1, 16'd1, 16'd0, 16'd0}, 0, 0, 1'b1);
    random_phase('{24'h000000, 4'd15, 16'd3, 16'd7, 16'd12}, 71, 0, 1'b0);
    random_phase('{24'hFFFFFF, 4'd0, 16'd0, 16'd5, 16'd9}, 0, 71, 1'b0);
    for (p = 0; p < 6; p++) begin
      s = rand_settings();
      case (p % 4)
        0: random_phase(s, 22, 22, 1'b0);
        1: random_phase(s, 0, 0, 1'b0);
        2: random_phase(s, 71, 0, 1'b0);
        default: random_phase(s, 0, 71, 1'b0);
      endcase
    end
    long_lockout_phase();

    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> keypad_code_lock_lockout.f
design/klk_pkg.sv
design/klk_stream_if.sv
design/klk_cfg_regs.sv
design/klk_core.sv
design/keypad_code_lock_lockout.sv
bench/klk_checker.sv
bench/tb_top.sv
